FILE: rtl/core/hgl_pkg.sv
package hgl_pkg;

    // Width of one axial coordinate.
    localparam int CB = 5;
    // Width of the hex distance and of the step index.
    localparam int NB = CB + 1;
    // Width of the s coordinate and of the interpolation state.
    localparam int SB = CB + 2;
    // Width of the remainder update before its correction.
    localparam int TB = NB + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;   // capture the endpoints of a new request
        logic setup;  // compute the distance and start the interpolation
        logic emit;   // move the current cell to the output and advance
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a cell this cycle
        logic at_last;   // current cell is the end cell
    } t_dp_stat;

    // Magnitude of a signed difference; it never reaches 2**NB.
    function automatic logic [NB-1:0] f_abs(input logic signed [SB-1:0] x);
        logic signed [SB-1:0] m;
        m = (x < 0) ? -x : x;
        return m[NB-1:0];
    endfunction

endpackage

FILE: rtl/core/hgl_axis.sv
module hgl_axis
    import hgl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_init,
    input  logic                 i_advance,
    input  logic signed [SB-1:0] i_start,
    input  logic signed [SB-1:0] i_delta,
    input  logic        [NB-1:0] i_n,
    input  logic                 i_tie_up,
    output logic signed [SB-1:0] o_value,
    output logic        [NB-1:0] o_err
);

    // The interpolated value is r_fl + r_rem / N with 0 <= r_rem < N.
    logic signed [SB-1:0] r_fl, n_fl;
    logic        [NB-1:0] r_rem, n_rem;
    logic signed [SB-1:0] r_d;

    logic signed [TB-1:0] w_t;
    logic signed [TB-1:0] w_n_ext;
    logic        [NB:0]   w_twice;
    logic                 w_up;

    assign w_t     = $signed({2'b00, r_rem}) + TB'(r_d);
    assign w_n_ext = $signed({2'b00, i_n});

    // The step never exceeds N in magnitude, so one correction suffices.
    always_comb begin
        n_fl  = r_fl;
        n_rem = r_rem;
        if (w_t < 0) begin
            n_fl  = r_fl - SB'(1);
            n_rem = NB'(w_t + w_n_ext);
        end else if (w_t >= w_n_ext) begin
            n_fl  = r_fl + SB'(1);
            n_rem = NB'(w_t - w_n_ext);
        end else begin
            n_rem = NB'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_fl  <= i_start;
            r_rem <= '0;
            r_d   <= i_delta;
        end else if (i_advance) begin
            r_fl  <= n_fl;
            r_rem <= n_rem;
        end
    end

    // Round to nearest; the tie direction is chosen per axis.
    assign w_twice = {r_rem, 1'b0};
    assign w_up    = (i_n != '0) &&
                     (i_tie_up ? (w_twice >= {1'b0, i_n}) : (w_twice > {1'b0, i_n}));
    assign o_value = r_fl + $signed({{(SB-1){1'b0}}, w_up});
    assign o_err   = w_up ? (i_n - r_rem) : r_rem;

endmodule

FILE: rtl/core/hgl_datapath.sv
module hgl_datapath
    import hgl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic signed [CB-1:0] i_start_q,
    input  logic signed [CB-1:0] i_start_r,
    input  logic signed [CB-1:0] i_end_q,
    input  logic signed [CB-1:0] i_end_r,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [CB-1:0] o_cell_q,
    output logic signed [CB-1:0] o_cell_r,
    output logic signed [SB-1:0] o_cell_s,
    output logic        [NB-1:0] o_step_index,
    output logic                 o_last_cell
);

    logic signed [CB-1:0] r_aq, r_ar, r_bq, r_br;
    logic        [NB-1:0] r_n;
    logic        [NB-1:0] r_i;

    logic signed [SB-1:0] w_aq, w_ar, w_as, w_bq, w_br, w_bs;
    logic signed [SB-1:0] w_dq, w_dr, w_ds;
    logic        [NB:0]   w_sum;

    logic signed [SB-1:0] w_qv, w_rv, w_sv;
    logic        [NB-1:0] w_eq, w_er, w_es;
    logic signed [SB-1:0] w_qf, w_rf, w_sf;

    logic                 r_out_valid;
    logic signed [CB-1:0] r_cell_q, r_cell_r;
    logic signed [SB-1:0] r_cell_s;
    logic        [NB-1:0] r_step;
    logic                 r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_aq <= i_start_q;
            r_ar <= i_start_r;
            r_bq <= i_end_q;
            r_br <= i_end_r;
        end
    end

    assign w_aq = SB'(r_aq);
    assign w_ar = SB'(r_ar);
    assign w_bq = SB'(r_bq);
    assign w_br = SB'(r_br);
    assign w_as = -w_aq - w_ar;
    assign w_bs = -w_bq - w_br;
    assign w_dq = w_bq - w_aq;
    assign w_dr = w_br - w_ar;
    assign w_ds = w_bs - w_as;

    // Hex distance is half the sum of the three cube differences.
    assign w_sum = {1'b0, f_abs(w_dq)} + {1'b0, f_abs(w_dr)} + {1'b0, f_abs(w_ds)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_n <= w_sum[NB:1];
            r_i <= '0;
        end else if (i_cmd.emit) begin
            r_i <= r_i + NB'(1);
        end
    end

    hgl_axis u_axis_q (
        .i_clk     (i_clk),
        .i_init    (i_cmd.setup),
        .i_advance (i_cmd.emit),
        .i_start   (w_aq),
        .i_delta   (w_dq),
        .i_n       (r_n),
        .i_tie_up  (1'b1),
        .o_value   (w_qv),
        .o_err     (w_eq)
    );

    hgl_axis u_axis_r (
        .i_clk     (i_clk),
        .i_init    (i_cmd.setup),
        .i_advance (i_cmd.emit),
        .i_start   (w_ar),
        .i_delta   (w_dr),
        .i_n       (r_n),
        .i_tie_up  (1'b1),
        .o_value   (w_rv),
        .o_err     (w_er)
    );

    hgl_axis u_axis_s (
        .i_clk     (i_clk),
        .i_init    (i_cmd.setup),
        .i_advance (i_cmd.emit),
        .i_start   (w_as),
        .i_delta   (w_ds),
        .i_n       (r_n),
        .i_tie_up  (1'b0),
        .o_value   (w_sv),
        .o_err     (w_es)
    );

    // The component with the largest error is rebuilt from the other two; on a tie s is preferred over r, and r over q.
    always_comb begin
        w_qf = w_qv;
        w_rf = w_rv;
        w_sf = w_sv;
        if (w_eq > w_er && w_eq > w_es) begin
            w_qf = -w_rv - w_sv;
        end else if (w_er > w_es) begin
            w_rf = -w_qv - w_sv;
        end else begin
            w_sf = -w_qv - w_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_cell_q <= w_qf[CB-1:0];
            r_cell_r <= w_rf[CB-1:0];
            r_cell_s <= w_sf;
            r_step   <= r_i;
            r_last   <= (r_i == r_n);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.at_last  = (r_i == r_n);

    assign o_out_valid  = r_out_valid;
    assign o_cell_q     = r_cell_q;
    assign o_cell_r     = r_cell_r;
    assign o_cell_s     = r_cell_s;
    assign o_step_index = r_step;
    assign o_last_cell  = r_last;

endmodule

FILE: rtl/core/hgl_ctrl.sv
module hgl_ctrl
    import hgl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_stat.out_free && i_stat.at_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // No request is taken while reset is held.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_RUN: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/hex_grid_line_draw.sv
// Channel Dir Handshake               Payload
// request in  i_in_valid/o_in_ready   i_start_q, i_start_r, i_end_q, i_end_r
// cell    out o_out_valid/i_out_ready o_cell_q, o_cell_r, o_cell_s, o_step_index, o_last_cell
//
// A request of hex distance N is first accepted, then N is computed, then its
// cells follow, one cell per cycle when the output is never stalled.
// The one-cell-per-cycle stepping of the three interpolators sets that rate.
// A stall on the cell channel holds the interpolators; no cell is lost.
// A new request is accepted while the end cell of the previous one still waits.
// Reset is synchronous and active low; it clears the controller and output valid.
module hex_grid_line_draw
    import hgl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [CB-1:0] i_start_q,
    input  logic signed [CB-1:0] i_start_r,
    input  logic signed [CB-1:0] i_end_q,
    input  logic signed [CB-1:0] i_end_r,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [CB-1:0] o_cell_q,
    output logic signed [CB-1:0] o_cell_r,
    output logic signed [SB-1:0] o_cell_s,
    output logic        [NB-1:0] o_step_index,
    output logic                 o_last_cell
);

    // The controller sequences accept, setup and emission. The datapath
    // holds the endpoints, the distance, three exact rational interpolators
    // (floor plus remainder over N) and the output register.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    hgl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    hgl_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_start_q    (i_start_q),
        .i_start_r    (i_start_r),
        .i_end_q      (i_end_q),
        .i_end_r      (i_end_r),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_cell_q     (o_cell_q),
        .o_cell_r     (o_cell_r),
        .o_cell_s     (o_cell_s),
        .o_step_index (o_step_index),
        .o_last_cell  (o_last_cell)
    );

    // Every emitted cell lies on the cube plane q + r + s = 0.
    logic signed [SB-1:0] w_s_chk;
    assign w_s_chk = -SB'(o_cell_q) - SB'(o_cell_r);

    a_setup_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_cmd.setup)
        else $error("setup did not follow an accepted request");

    a_idle_after_end_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_stat.at_last) |=> o_in_ready)
        else $error("not ready for a request after the end cell");

    a_emit_shows_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("emitted cell not shown on the output");

    a_cube_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cell_s == w_s_chk))
        else $error("cell is off the cube plane");

endmodule
